/* rtl/mrot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrot_pkg
// Shared types and constants of the minimum rotation matrix block.
// ----------------------------------------------------------------------------
package mrot_pkg;

  localparam int Q_SHIFT = 14;
  localparam int Q_ONE   = 16384;
  localparam int UW      = 16;
  localparam int CW      = 31;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PAR      = 2'd1;
  localparam logic [1:0] ST_SRC_ZERO = 2'd2;
  localparam logic [1:0] ST_TGT_ZERO = 2'd3;

  typedef logic [2:0][UW-1:0] uvec_t;
  typedef logic [2:0][CW-1:0] cvec_t;

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic [1:0]         status;
  } out_t;

endpackage

/* rtl/mrot_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrot_norm
// Pipelined normalizer: squares, sum, one square root bit per stage, then one
// quotient bit per stage of the rounded division into Q2.14 unit components.
// ----------------------------------------------------------------------------
module mrot_norm #(
  parameter int NV  = 1,
  parameter int VW  = 31,
  parameter int SBW = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [NV-1:0][2:0][VW-1:0]            in_vec,
  input  logic [SBW-1:0]                        in_sb,
  output logic                                  out_valid,
  output logic [NV-1:0][2:0][mrot_pkg::UW-1:0]  out_vec,
  output logic [SBW-1:0]                        out_sb
);
  import mrot_pkg::*;

  localparam int SW = 2 * VW;
  localparam int NI = VW;
  localparam int MW = VW + Q_SHIFT;
  localparam int RW = MW + 1;
  localparam int QB = Q_SHIFT + 1;

  logic [NV-1:0][2:0][VW-1:0] abs_v;

  always_comb begin
    for (int n = 0; n < NV; n++) begin
      for (int k = 0; k < 3; k++) begin
        abs_v[n][k] = in_vec[n][k][VW-1] ? VW'(-in_vec[n][k]) : in_vec[n][k];
      end
    end
  end

  // square stage
  logic                       a_vld;
  logic [SBW-1:0]             a_sb;
  logic [NV-1:0][2:0]         a_neg;
  logic [NV-1:0][2:0][MW-1:0] a_mag;
  logic [NV-1:0][2:0][SW-1:0] a_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sb <= in_sb;
      for (int n = 0; n < NV; n++) begin
        for (int k = 0; k < 3; k++) begin
          a_neg[n][k] <= in_vec[n][k][VW-1];
          a_mag[n][k] <= MW'(abs_v[n][k]) << Q_SHIFT;
          a_sq[n][k]  <= abs_v[n][k] * abs_v[n][k];
        end
      end
    end
  end

  // sum stage
  logic                       b_vld;
  logic [SBW-1:0]             b_sb;
  logic [NV-1:0][2:0]         b_neg;
  logic [NV-1:0][2:0][MW-1:0] b_mag;
  logic [NV-1:0][SW-1:0]      b_sum;
  logic [NV-1:0]              b_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sb  <= a_sb;
      b_neg <= a_neg;
      b_mag <= a_mag;
      for (int n = 0; n < NV; n++) begin
        b_sum[n]  <= a_sq[n][0] + a_sq[n][1] + a_sq[n][2];
        b_zero[n] <= (a_mag[n][0] == '0) && (a_mag[n][1] == '0) && (a_mag[n][2] == '0);
      end
    end
  end

  // square root, one result bit per stage
  logic [NV-1:0][SW-1:0]      q_n    [NI];
  logic [NV-1:0][SW-1:0]      q_r    [NI];
  logic [NV-1:0][2:0][MW-1:0] q_mag  [NI];
  logic [NV-1:0][2:0]         q_neg  [NI];
  logic [NV-1:0]              q_zero [NI];
  logic [SBW-1:0]             q_sb   [NI];
  logic [NI-1:0]              q_vld;

  for (genvar i = 0; i < NI; i++) begin : g_sqrt
    localparam logic [SW:0] BIT = (SW+1)'(1) << (SW - 2 - 2 * i);

    logic [NV-1:0][SW-1:0]      n_in;
    logic [NV-1:0][SW-1:0]      r_in;
    logic [NV-1:0][SW-1:0]      n_nx;
    logic [NV-1:0][SW-1:0]      r_nx;
    logic [NV-1:0][SW:0]        trial;
    logic [NV-1:0][2:0][MW-1:0] mag_in;
    logic [NV-1:0][2:0]         neg_in;
    logic [NV-1:0]              zero_in;
    logic [SBW-1:0]             sb_in;
    logic                       vld_in;

    if (i == 0) begin : g_first
      assign n_in    = b_sum;
      assign r_in    = '0;
      assign mag_in  = b_mag;
      assign neg_in  = b_neg;
      assign zero_in = b_zero;
      assign sb_in   = b_sb;
      assign vld_in  = b_vld;
    end else begin : g_next
      assign n_in    = q_n[i-1];
      assign r_in    = q_r[i-1];
      assign mag_in  = q_mag[i-1];
      assign neg_in  = q_neg[i-1];
      assign zero_in = q_zero[i-1];
      assign sb_in   = q_sb[i-1];
      assign vld_in  = q_vld[i-1];
    end

    always_comb begin
      for (int n = 0; n < NV; n++) begin
        trial[n] = {1'b0, r_in[n]} + BIT;
        if ({1'b0, n_in[n]} >= trial[n]) begin
          n_nx[n] = SW'({1'b0, n_in[n]} - trial[n]);
          r_nx[n] = SW'({2'b0, r_in[n][SW-1:1]} + BIT);
        end else begin
          n_nx[n] = n_in[n];
          r_nx[n] = {1'b0, r_in[n][SW-1:1]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        q_vld[i] <= 1'b0;
      end else if (en) begin
        q_vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_n[i]    <= n_nx;
        q_r[i]    <= r_nx;
        q_mag[i]  <= mag_in;
        q_neg[i]  <= neg_in;
        q_zero[i] <= zero_in;
        q_sb[i]   <= sb_in;
      end
    end
  end

  // rounding offset stage
  logic                       p_vld;
  logic [SBW-1:0]             p_sb;
  logic [NV-1:0][2:0]         p_neg;
  logic [NV-1:0]              p_zero;
  logic [NV-1:0][VW-1:0]      p_l;
  logic [NV-1:0][2:0][RW-1:0] p_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= q_vld[NI-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_sb   <= q_sb[NI-1];
      p_neg  <= q_neg[NI-1];
      p_zero <= q_zero[NI-1];
      for (int n = 0; n < NV; n++) begin
        p_l[n] <= q_r[NI-1][n][VW-1:0];
        for (int k = 0; k < 3; k++) begin
          p_rem[n][k] <= RW'(q_mag[NI-1][n][k]) + RW'(q_r[NI-1][n][VW-1:1]);
        end
      end
    end
  end

  // division, one quotient bit per stage
  logic [NV-1:0][2:0][RW-1:0] d_rem  [QB];
  logic [NV-1:0][2:0][QB-1:0] d_q    [QB];
  logic [NV-1:0][VW-1:0]      d_l    [QB];
  logic [NV-1:0][2:0]         d_neg  [QB];
  logic [NV-1:0]              d_zero [QB];
  logic [SBW-1:0]             d_sb   [QB];
  logic [QB-1:0]              d_vld;

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;

    logic [NV-1:0][2:0][RW-1:0] rem_in;
    logic [NV-1:0][2:0][QB-1:0] qt_in;
    logic [NV-1:0][VW-1:0]      l_in;
    logic [NV-1:0][2:0]         neg_in;
    logic [NV-1:0]              zero_in;
    logic [SBW-1:0]             sb_in;
    logic                       vld_in;
    logic [NV-1:0][RW-1:0]      den;
    logic [NV-1:0][2:0][RW-1:0] rem_nx;
    logic [NV-1:0][2:0][QB-1:0] qt_nx;

    if (j == 0) begin : g_first
      assign rem_in  = p_rem;
      assign qt_in   = '0;
      assign l_in    = p_l;
      assign neg_in  = p_neg;
      assign zero_in = p_zero;
      assign sb_in   = p_sb;
      assign vld_in  = p_vld;
    end else begin : g_next
      assign rem_in  = d_rem[j-1];
      assign qt_in   = d_q[j-1];
      assign l_in    = d_l[j-1];
      assign neg_in  = d_neg[j-1];
      assign zero_in = d_zero[j-1];
      assign sb_in   = d_sb[j-1];
      assign vld_in  = d_vld[j-1];
    end

    always_comb begin
      for (int n = 0; n < NV; n++) begin
        den[n] = RW'(l_in[n]) << SH;
        for (int k = 0; k < 3; k++) begin
          if (rem_in[n][k] >= den[n]) begin
            rem_nx[n][k] = rem_in[n][k] - den[n];
            qt_nx[n][k]  = qt_in[n][k] | (QB'(1) << SH);
          end else begin
            rem_nx[n][k] = rem_in[n][k];
            qt_nx[n][k]  = qt_in[n][k];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[j] <= 1'b0;
      end else if (en) begin
        d_vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[j]  <= rem_nx;
        d_q[j]    <= qt_nx;
        d_l[j]    <= l_in;
        d_neg[j]  <= neg_in;
        d_zero[j] <= zero_in;
        d_sb[j]   <= sb_in;
      end
    end
  end

  // saturate and sign
  logic [NV-1:0][2:0][UW-1:0] mag_sat;
  logic [NV-1:0][2:0][UW-1:0] unit;

  always_comb begin
    for (int n = 0; n < NV; n++) begin
      for (int k = 0; k < 3; k++) begin
        mag_sat[n][k] = (UW'(d_q[QB-1][n][k]) > UW'(Q_ONE)) ? UW'(Q_ONE)
                                                             : UW'(d_q[QB-1][n][k]);
        if (d_zero[QB-1][n]) begin
          unit[n][k] = '0;
        end else begin
          unit[n][k] = d_neg[QB-1][n][k] ? UW'(-mag_sat[n][k]) : mag_sat[n][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= unit;
      out_sb  <= d_sb[QB-1];
    end
  end

endmodule

/* rtl/min_rotation_matrix_3d_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_rotation_matrix_3d_top
// Minimum rotation matrix between a source and a target direction in Q2.14.
// ----------------------------------------------------------------------------
// The block accepts one vector pair per clock unless the result side stalls,
// and returns the matching rotations in order. Three normalizers lie in series
// (from/to, then the common normal, then the two in-plane axes), each
// 50 stages deep: 31 square root stages and 15 division stages, one bit each,
// plus square, sum, offset and sign stages; six more stages hold the cross
// products, the parallel test and the matrix products and sums. A stall on the
// result side freezes the whole pipeline, so nothing is lost or repeated.
module min_rotation_matrix_3d_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [14:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  mrot_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mrot_pkg::out_t  out_data
);
  import mrot_pkg::*;

  localparam int SW1 = 2 + 6 * UW;
  localparam int SW2 = 2 + 9 * UW;

  function automatic cvec_t cross3(uvec_t a, uvec_t b);
    logic signed [31:0] p [6];
    cvec_t c;
    p[0] = $signed(a[1]) * $signed(b[2]);
    p[1] = $signed(a[2]) * $signed(b[1]);
    p[2] = $signed(a[2]) * $signed(b[0]);
    p[3] = $signed(a[0]) * $signed(b[2]);
    p[4] = $signed(a[0]) * $signed(b[1]);
    p[5] = $signed(a[1]) * $signed(b[0]);
    c[0] = CW'(p[0] - p[1]);
    c[1] = CW'(p[2] - p[3]);
    c[2] = CW'(p[4] - p[5]);
    return c;
  endfunction

  function automatic logic [UW-1:0] round_q28(logic signed [33:0] s);
    logic [33:0]   mag;
    logic [33:0]   q;
    logic [UW-1:0] sat;
    mag = s[33] ? 34'(-s) : 34'(s);
    q   = (mag + 34'(1 << (Q_SHIFT - 1))) >> Q_SHIFT;
    sat = (q > 34'(Q_ONE)) ? UW'(Q_ONE) : UW'(q);
    return s[33] ? UW'(-sat) : sat;
  endfunction

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  logic [14:0] thr;
  logic [29:0] thr_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= 15'd16;
      thr_sq <= 30'd256;
    end else begin
      if (cfg_valid) begin
        thr <= cfg_data;
      end
      thr_sq <= thr * thr;
    end
  end

  // normalize source and target
  logic [1:0]             in_st;
  logic [1:0][2:0][CW-1:0] n1_in;
  logic                   n1_vld;
  logic [1:0][2:0][UW-1:0] n1_out;
  logic [1:0]             n1_st;

  always_comb begin
    if (in_data.from_x == '0 && in_data.from_y == '0 && in_data.from_z == '0) begin
      in_st = ST_SRC_ZERO;
    end else if (in_data.to_x == '0 && in_data.to_y == '0 && in_data.to_z == '0) begin
      in_st = ST_TGT_ZERO;
    end else begin
      in_st = ST_OK;
    end
    n1_in[0][0] = {in_data.from_x[15], in_data.from_x, 14'd0};
    n1_in[0][1] = {in_data.from_y[15], in_data.from_y, 14'd0};
    n1_in[0][2] = {in_data.from_z[15], in_data.from_z, 14'd0};
    n1_in[1][0] = {in_data.to_x[15], in_data.to_x, 14'd0};
    n1_in[1][1] = {in_data.to_y[15], in_data.to_y, 14'd0};
    n1_in[1][2] = {in_data.to_z[15], in_data.to_z, 14'd0};
  end

  mrot_norm #(.NV(2), .VW(CW), .SBW(2)) u_norm_ft (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (in_valid),
    .in_vec   (n1_in),
    .in_sb    (in_st),
    .out_valid(n1_vld),
    .out_vec  (n1_out),
    .out_sb   (n1_st)
  );

  // common normal and parallel test
  logic        c1_vld, c2_vld, c3_vld;
  logic [1:0]  c1_st, c2_st, c3_st;
  uvec_t       c1_f, c1_t, c2_f, c2_t, c3_f, c3_t;
  cvec_t       c1_c, c2_c, c3_c;
  logic [2:0][2*CW-1:0] c2_sq;
  logic [2*CW-1:0]      sr;
  logic [CW-1:0]        c_abs [3];
  logic                 par;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_abs[k] = c1_c[k][CW-1] ? CW'(-c1_c[k]) : c1_c[k];
    end
    sr  = c2_sq[0] + c2_sq[1] + c2_sq[2];
    par = (sr == '0) || (sr < (2*CW)'({thr_sq, 28'd0}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
      c3_vld <= 1'b0;
    end else if (adv) begin
      c1_vld <= n1_vld;
      c2_vld <= c1_vld;
      c3_vld <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_st <= n1_st;
      c1_f  <= n1_out[0];
      c1_t  <= n1_out[1];
      c1_c  <= cross3(n1_out[0], n1_out[1]);
      c2_st <= c1_st;
      c2_f  <= c1_f;
      c2_t  <= c1_t;
      c2_c  <= c1_c;
      for (int k = 0; k < 3; k++) begin
        c2_sq[k] <= c_abs[k] * c_abs[k];
      end
      c3_st <= (c2_st == ST_OK && par) ? ST_PAR : c2_st;
      c3_f  <= c2_f;
      c3_t  <= c2_t;
      c3_c  <= c2_c;
    end
  end

  // normalize the common normal
  logic                    n2_vld;
  logic [0:0][2:0][UW-1:0] n2_out;
  logic [SW1-1:0]          n2_sb;
  logic [0:0][2:0][CW-1:0] n2_in;

  assign n2_in[0] = c3_c;

  mrot_norm #(.NV(1), .VW(CW), .SBW(SW1)) u_norm_r (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (c3_vld),
    .in_vec   (n2_in),
    .in_sb    ({c3_st, c3_f, c3_t}),
    .out_valid(n2_vld),
    .out_vec  (n2_out),
    .out_sb   (n2_sb)
  );

  // in-plane axes
  logic                    x_vld;
  logic [1:0]              x_st;
  uvec_t                   x_f, x_t, x_r;
  logic [1:0][2:0][CW-1:0] x_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
    end else if (adv) begin
      x_vld <= n2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_st   <= n2_sb[SW1-1 -: 2];
      x_f    <= n2_sb[2*3*UW-1 -: 3*UW];
      x_t    <= n2_sb[3*UW-1:0];
      x_r    <= n2_out[0];
      x_w[0] <= cross3(n2_sb[2*3*UW-1 -: 3*UW], n2_out[0]);
      x_w[1] <= cross3(n2_sb[3*UW-1:0], n2_out[0]);
    end
  end

  logic                    n3_vld;
  logic [1:0][2:0][UW-1:0] n3_out;
  logic [SW2-1:0]          n3_sb;

  mrot_norm #(.NV(2), .VW(CW), .SBW(SW2)) u_norm_ab (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (x_vld),
    .in_vec   (x_w),
    .in_sb    ({x_st, x_f, x_t, x_r}),
    .out_valid(n3_vld),
    .out_vec  (n3_out),
    .out_sb   (n3_sb)
  );

  // matrix products and sums
  uvec_t m_f, m_t, m_r;
  logic                    m1_vld;
  logic [1:0]              m1_st;
  logic signed [31:0]      m1_p [3][3][3];
  logic signed [33:0]      m_sum [3][3];
  logic [UW-1:0]           m_ent [3][3];

  assign m_f = n3_sb[3*3*UW-1 -: 3*UW];
  assign m_t = n3_sb[2*3*UW-1 -: 3*UW];
  assign m_r = n3_sb[3*UW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= n3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_st <= n3_sb[SW2-1 -: 2];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m1_p[i][j][0] <= $signed(m_t[i]) * $signed(m_f[j]);
          m1_p[i][j][1] <= $signed(m_r[i]) * $signed(m_r[j]);
          m1_p[i][j][2] <= $signed(n3_out[1][i]) * $signed(n3_out[0][j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_sum[i][j] = 34'(m1_p[i][j][0]) + 34'(m1_p[i][j][1]) + 34'(m1_p[i][j][2]);
        if (m1_st == ST_OK) begin
          m_ent[i][j] = round_q28(m_sum[i][j]);
        end else if (m1_st == ST_PAR && i == j) begin
          m_ent[i][j] = UW'(Q_ONE);
        end else begin
          m_ent[i][j] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.m00    <= m_ent[0][0];
      out_data.m01    <= m_ent[0][1];
      out_data.m02    <= m_ent[0][2];
      out_data.m10    <= m_ent[1][0];
      out_data.m11    <= m_ent[1][1];
      out_data.m12    <= m_ent[1][2];
      out_data.m20    <= m_ent[2][0];
      out_data.m21    <= m_ent[2][1];
      out_data.m22    <= m_ent[2][2];
      out_data.status <= m1_st;
    end
  end

  a_par_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_PAR |->
      out_data.m00 == Q_ONE && out_data.m11 == Q_ONE && out_data.m22 == Q_ONE &&
      out_data.m01 == 0 && out_data.m10 == 0)
    else $error("parallel transaction without identity matrix");

  a_zero_matrix: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_SRC_ZERO || out_data.status == ST_TGT_ZERO) |->
      out_data.m00 == 0 && out_data.m11 == 0 && out_data.m22 == 0)
    else $error("zero vector transaction with nonzero matrix");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> thr == $past(cfg_data))
    else $error("threshold write lost");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule
